// ===== rtl/core/complex_arith_unit_defines.svh =====
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("complex_arith_unit: check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define CAU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("complex_arith_unit: check failed");

`endif

// ===== rtl/core/cau_pkg.sv =====
// Shared constants, types and helper functions of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int OP_W       = 3;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAG_W      = PROD_W;
  localparam int DIV_STEPS  = DATA_W;
  localparam int DIV_REM_W  = MAG_W + 1;
  localparam int ROOT_W     = DATA_W;
  localparam int SQ_REM_W   = ROOT_W + 3;
  localparam int ANG_W      = 26;
  localparam int ANG_FRAC   = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W   = DATA_W + ANG_FRAC + 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_W-1:0] OP_NEG  = 3'd4;
  localparam logic [OP_W-1:0] OP_CONJ = 3'd5;
  localparam logic [OP_W-1:0] OP_PASS = 3'd6;

  // Angle case of the result point
  localparam int QUAD_W = 3;
  localparam logic [QUAD_W-1:0] QUAD_RIGHT  = 3'd0;
  localparam logic [QUAD_W-1:0] QUAD_LEFT   = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_UP     = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_DOWN   = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_ORIGIN = 3'd4;

  // Angle constants, degrees in Q.16
  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * (1 << ANG_FRAC));
  localparam logic signed [ANG_W-1:0] ANG_M90 = ANG_W'(-90 * (1 << ANG_FRAC));
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * (1 << ANG_FRAC));
  localparam logic signed [ANG_W-1:0] ANG_270 = ANG_W'(270 * (1 << ANG_FRAC));

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic sat;
    data_t val;
  } clip_t;

  // Per-item data that rides along the divider pipeline
  typedef struct packed {
    logic  is_div;
    logic  dz;
    logic  sat;
    data_t re;
    data_t im;
  } side_t;

  typedef struct packed {
    logic dz;
    logic sat;
  } flag_t;

  typedef struct packed {
    data_t                   re;
    data_t                   im;
    logic [ROOT_W-1:0]       mag;
    logic signed [ANG_W-1:0] ang;
    logic                    dz;
    logic                    sat;
  } result_t;

  // Sign-magnitude value to signed DATA_W, clipped at both ends
  function automatic clip_t clip_sm(input logic neg, input logic [MAG_W-1:0] mag);
    clip_t c;
    logic [MAG_W-1:0] lim;
    lim   = MAG_W'(1) << (DATA_W - 1);
    c.sat = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        c.sat = 1'b1;
        c.val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        c.val = data_t'(-mag[DATA_W-1:0]);
      end
    end else begin
      if (mag >= lim) begin
        c.sat = 1'b1;
        c.val = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        c.val = data_t'(mag[DATA_W-1:0]);
      end
    end
    return c;
  endfunction

  // atan(2^-k) in degrees, Q.16
  function automatic logic [ANG_W-1:0] step_angle(input int k);
    logic [ANG_W-1:0] a;
    unique case (k)
      0:  a = 26'd2949120;
      1:  a = 26'd1740967;
      2:  a = 26'd919879;
      3:  a = 26'd466945;
      4:  a = 26'd234379;
      5:  a = 26'd117304;
      6:  a = 26'd58666;
      7:  a = 26'd29335;
      8:  a = 26'd14668;
      9:  a = 26'd7334;
      10: a = 26'd3667;
      11: a = 26'd1833;
      12: a = 26'd917;
      13: a = 26'd458;
      14: a = 26'd229;
      15: a = 26'd115;
      16: a = 26'd57;
      17: a = 26'd29;
      18: a = 26'd14;
      19: a = 26'd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cau_divider.sv =====
// Pipelined restoring divider: both quotient parts share one divisor.
`default_nettype none

module cau_divider (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  cau_pkg::side_t                           in_side,
  input  logic [1:0]                               in_neg,
  input  logic [1:0][cau_pkg::MAG_W-1:0]           in_mag,
  input  logic [cau_pkg::MAG_W-1:0]                in_d,
  output logic                                     out_valid,
  output cau_pkg::side_t                           out_side,
  output logic [1:0]                               out_neg,
  output logic [1:0]                               out_ovf,
  output logic [1:0][cau_pkg::DATA_W-1:0]          out_q
);

  logic                                  vld  [0:cau_pkg::DIV_STEPS];
  cau_pkg::side_t                        side [0:cau_pkg::DIV_STEPS];
  logic [1:0]                            neg  [0:cau_pkg::DIV_STEPS];
  logic [1:0]                            ovf  [0:cau_pkg::DIV_STEPS];
  logic [1:0][cau_pkg::DIV_REM_W-1:0]    rem  [0:cau_pkg::DIV_STEPS];
  logic [1:0][cau_pkg::DATA_W-1:0]       nb   [0:cau_pkg::DIV_STEPS];
  logic [1:0][cau_pkg::DATA_W-1:0]       q    [0:cau_pkg::DIV_STEPS];
  logic [cau_pkg::MAG_W-1:0]             d    [0:cau_pkg::DIV_STEPS];
  logic [1:0]                            ovf0;

  // Quotient would need more than DATA_W bits: m >= d * 2^FRAC
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      ovf0[p] = {{cau_pkg::FRAC_W{1'b0}}, in_mag[p]} >= {in_d, {cau_pkg::FRAC_W{1'b0}}};
    end
  end

  // Entry stage: integer part of the dividend seeds the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      neg[0]  <= in_neg;
      ovf[0]  <= ovf0;
      d[0]    <= in_d;
      for (int p = 0; p < 2; p++) begin
        rem[0][p] <= cau_pkg::DIV_REM_W'(in_mag[p] >> cau_pkg::FRAC_W);
        nb[0][p]  <= {in_mag[p][cau_pkg::FRAC_W-1:0],
                      {(cau_pkg::DATA_W-cau_pkg::FRAC_W){1'b0}}};
        q[0][p]   <= '0;
      end
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < cau_pkg::DIV_STEPS; k++) begin : g_step
    logic [1:0][cau_pkg::DIV_REM_W-1:0] rem_sh;
    logic [1:0][cau_pkg::DIV_REM_W-1:0] rem_next;
    logic [1:0]                         qb;

    always_comb begin
      for (int p = 0; p < 2; p++) begin
        rem_sh[p]   = {rem[k][p][cau_pkg::DIV_REM_W-2:0], nb[k][p][cau_pkg::DATA_W-1]};
        qb[p]       = rem_sh[p] >= {1'b0, d[k]};
        rem_next[p] = qb[p] ? rem_sh[p] - {1'b0, d[k]} : rem_sh[p];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
        neg[k+1]  <= neg[k];
        ovf[k+1]  <= ovf[k];
        d[k+1]    <= d[k];
        rem[k+1]  <= rem_next;
        for (int p = 0; p < 2; p++) begin
          nb[k+1][p] <= {nb[k][p][cau_pkg::DATA_W-2:0], 1'b0};
          q[k+1][p]  <= {q[k][p][cau_pkg::DATA_W-2:0], qb[p]};
        end
      end
    end
  end

  assign out_valid = vld[cau_pkg::DIV_STEPS];
  assign out_side  = side[cau_pkg::DIV_STEPS];
  assign out_neg   = neg[cau_pkg::DIV_STEPS];
  assign out_ovf   = ovf[cau_pkg::DIV_STEPS];
  assign out_q     = q[cau_pkg::DIV_STEPS];

endmodule

`default_nettype wire

// ===== rtl/core/cau_polar.sv =====
// Polar form of the result: pipelined integer square root and CORDIC angle.
`default_nettype none

module cau_polar (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  cau_pkg::data_t         in_re,
  input  cau_pkg::data_t         in_im,
  input  cau_pkg::flag_t         in_flags,
  output logic                   out_valid,
  output cau_pkg::result_t       out_res
);

  // Front stage: squares and CORDIC start vector
  logic                                  pa_vld;
  cau_pkg::data_t                        pa_re;
  cau_pkg::data_t                        pa_im;
  cau_pkg::flag_t                        pa_flags;
  logic signed [cau_pkg::PROD_W-1:0]     pa_sq_re;
  logic signed [cau_pkg::PROD_W-1:0]     pa_sq_im;
  logic signed [cau_pkg::CORDIC_W-1:0]   pa_x;
  logic signed [cau_pkg::CORDIC_W-1:0]   pa_y;
  logic [cau_pkg::QUAD_W-1:0]            pa_quad;

  logic signed [cau_pkg::CORDIC_W-1:0]   re_w;
  logic signed [cau_pkg::CORDIC_W-1:0]   im_w;
  logic signed [cau_pkg::CORDIC_W-1:0]   x0;
  logic signed [cau_pkg::CORDIC_W-1:0]   y0;
  logic [cau_pkg::QUAD_W-1:0]            quad0;

  // Step pipeline
  logic                                  vld  [0:cau_pkg::ROOT_W];
  cau_pkg::data_t                        re_s [0:cau_pkg::ROOT_W];
  cau_pkg::data_t                        im_s [0:cau_pkg::ROOT_W];
  cau_pkg::flag_t                        fl_s [0:cau_pkg::ROOT_W];
  logic [cau_pkg::QUAD_W-1:0]            qd_s [0:cau_pkg::ROOT_W];
  logic [cau_pkg::PROD_W-1:0]            rad  [0:cau_pkg::ROOT_W];
  logic [cau_pkg::SQ_REM_W-1:0]          srem [0:cau_pkg::ROOT_W];
  logic [cau_pkg::ROOT_W-1:0]            root [0:cau_pkg::ROOT_W];
  logic signed [cau_pkg::CORDIC_W-1:0]   x_s  [0:cau_pkg::ROOT_W];
  logic signed [cau_pkg::CORDIC_W-1:0]   y_s  [0:cau_pkg::ROOT_W];
  logic signed [cau_pkg::ANG_W-1:0]      z_s  [0:cau_pkg::ROOT_W];

  logic signed [cau_pkg::ANG_W-1:0]      z_fin;
  logic signed [cau_pkg::ANG_W-1:0]      z_clip;
  logic signed [cau_pkg::ANG_W-1:0]      ang;

  // Start vector: left half is mirrored through the origin
  always_comb begin
    re_w = cau_pkg::CORDIC_W'(in_re);
    im_w = cau_pkg::CORDIC_W'(in_im);
    x0   = (in_re[cau_pkg::DATA_W-1] ? -re_w : re_w) <<< cau_pkg::ANG_FRAC;
    y0   = (in_re[cau_pkg::DATA_W-1] ? -im_w : im_w) <<< cau_pkg::ANG_FRAC;
    priority if (in_re > 0) begin
      quad0 = cau_pkg::QUAD_RIGHT;
    end else if (in_re < 0) begin
      quad0 = cau_pkg::QUAD_LEFT;
    end else if (in_im > 0) begin
      quad0 = cau_pkg::QUAD_UP;
    end else if (in_im < 0) begin
      quad0 = cau_pkg::QUAD_DOWN;
    end else begin
      quad0 = cau_pkg::QUAD_ORIGIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_vld <= 1'b0;
    end else if (en) begin
      pa_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_re    <= in_re;
      pa_im    <= in_im;
      pa_flags <= in_flags;
      pa_sq_re <= in_re * in_re;
      pa_sq_im <= in_im * in_im;
      pa_x     <= x0;
      pa_y     <= y0;
      pa_quad  <= quad0;
    end
  end

  // Radicand sum opens the step pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= pa_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_s[0] <= pa_re;
      im_s[0] <= pa_im;
      fl_s[0] <= pa_flags;
      qd_s[0] <= pa_quad;
      rad[0]  <= $unsigned(pa_sq_re) + $unsigned(pa_sq_im);
      srem[0] <= '0;
      root[0] <= '0;
      x_s[0]  <= pa_x;
      y_s[0]  <= pa_y;
      z_s[0]  <= '0;
    end
  end

  // One root bit per stage; CORDIC rotations in the first stages
  for (genvar k = 0; k < cau_pkg::ROOT_W; k++) begin : g_step
    logic [cau_pkg::SQ_REM_W-1:0] rem_sh;
    logic [cau_pkg::SQ_REM_W-1:0] trial;
    logic                         rb;

    always_comb begin
      rem_sh = {srem[k][cau_pkg::SQ_REM_W-3:0], rad[k][cau_pkg::PROD_W-1 -: 2]};
      trial  = {1'b0, root[k], 2'b01};
      rb     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        re_s[k+1] <= re_s[k];
        im_s[k+1] <= im_s[k];
        fl_s[k+1] <= fl_s[k];
        qd_s[k+1] <= qd_s[k];
        rad[k+1]  <= rad[k] << 2;
        srem[k+1] <= rb ? rem_sh - trial : rem_sh;
        root[k+1] <= {root[k][cau_pkg::ROOT_W-2:0], rb};
      end
    end

    if (k < cau_pkg::CORDIC_STEPS) begin : g_rot
      logic signed [cau_pkg::ANG_W-1:0] step;
      assign step = $signed(cau_pkg::step_angle(k));

      // Vectoring: rotate toward the x axis
      always_ff @(posedge clk) begin
        if (en) begin
          if (!y_s[k][cau_pkg::CORDIC_W-1]) begin
            x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
            y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
            z_s[k+1] <= z_s[k] + step;
          end else begin
            x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
            y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
            z_s[k+1] <= z_s[k] - step;
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          x_s[k+1] <= x_s[k];
          y_s[k+1] <= y_s[k];
          z_s[k+1] <= z_s[k];
        end
      end
    end
  end

  // Final angle: clip to a half turn, then place by quadrant case
  always_comb begin
    z_fin = z_s[cau_pkg::ROOT_W];
    if (z_fin > cau_pkg::ANG_90) begin
      z_clip = cau_pkg::ANG_90;
    end else if (z_fin < cau_pkg::ANG_M90) begin
      z_clip = cau_pkg::ANG_M90;
    end else begin
      z_clip = z_fin;
    end
    unique case (qd_s[cau_pkg::ROOT_W])
      cau_pkg::QUAD_RIGHT: ang = z_clip;
      cau_pkg::QUAD_LEFT:  ang = z_clip + cau_pkg::ANG_180;
      cau_pkg::QUAD_UP:    ang = cau_pkg::ANG_90;
      cau_pkg::QUAD_DOWN:  ang = cau_pkg::ANG_270;
      default:             ang = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[cau_pkg::ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.re  <= re_s[cau_pkg::ROOT_W];
      out_res.im  <= im_s[cau_pkg::ROOT_W];
      out_res.mag <= root[cau_pkg::ROOT_W];
      out_res.ang <= ang;
      out_res.dz  <= fl_s[cau_pkg::ROOT_W].dz;
      out_res.sat <= fl_s[cau_pkg::ROOT_W].sat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/complex_arith_unit.sv =====
// Complex arithmetic unit top level: operand front end, divider, polar stage, output buffer.
//
//   channel | signals                                   | transfer when
//   --------+-------------------------------------------+----------------------
//   in      | in_valid in_ready op a_re a_im b_re b_im  | in_valid && in_ready
//   out     | out_valid out_ready res_re res_im          | out_valid && out_ready
//           | magnitude angle_deg divide_by_zero saturated
//
// One item per cycle sustained while the pipeline is not held.
// The 32-stage divider and the 32-stage square root follow each other;
// the CORDIC runs beside the square root.
// rst (synchronous) clears valid bits and the pointers and count of the two-entry output buffer only.
// The pipeline holds only when its last stage is full and the buffer is full
// and not being read; otherwise input is taken while results wait.
`default_nettype none

`include "complex_arith_unit_defines.svh"

module complex_arith_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cau_pkg::OP_W-1:0]             op,
  input  logic signed [cau_pkg::DATA_W-1:0]    a_re,
  input  logic signed [cau_pkg::DATA_W-1:0]    a_im,
  input  logic signed [cau_pkg::DATA_W-1:0]    b_re,
  input  logic signed [cau_pkg::DATA_W-1:0]    b_im,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cau_pkg::DATA_W-1:0]    res_re,
  output logic signed [cau_pkg::DATA_W-1:0]    res_im,
  output logic [cau_pkg::ROOT_W-1:0]           magnitude,
  output logic signed [cau_pkg::ANG_W-1:0]     angle_deg,
  output logic                                 divide_by_zero,
  output logic                                 saturated
);

  function automatic logic signed [cau_pkg::SUM_W-1:0] sx_d(input cau_pkg::data_t v);
    return cau_pkg::SUM_W'(v);
  endfunction

  function automatic logic signed [cau_pkg::SUM_W-1:0] sx_p(
    input logic signed [cau_pkg::PROD_W-1:0] v);
    return cau_pkg::SUM_W'(v);
  endfunction

  logic adv;
  logic push;
  logic pop;

  // Stage 1: operands and products
  logic                               s1_valid;
  logic [cau_pkg::OP_W-1:0]           s1_op;
  cau_pkg::data_t                     s1_ar;
  cau_pkg::data_t                     s1_ai;
  cau_pkg::data_t                     s1_br;
  cau_pkg::data_t                     s1_bi;
  logic signed [cau_pkg::PROD_W-1:0]  s1_p_rr;
  logic signed [cau_pkg::PROD_W-1:0]  s1_p_ii;
  logic signed [cau_pkg::PROD_W-1:0]  s1_p_ri;
  logic signed [cau_pkg::PROD_W-1:0]  s1_p_ir;
  logic signed [cau_pkg::PROD_W-1:0]  s1_sq_r;
  logic signed [cau_pkg::PROD_W-1:0]  s1_sq_i;

  // Stage 2: exact sums
  logic                               s2_valid;
  logic signed [cau_pkg::SUM_W-1:0]   s2_sum_re;
  logic signed [cau_pkg::SUM_W-1:0]   s2_sum_im;
  logic [cau_pkg::MAG_W-1:0]          s2_d;
  logic                               s2_dz;
  logic                               s2_is_div;
  logic                               s2_is_mul;
  logic signed [cau_pkg::SUM_W-1:0]   sum_re;
  logic signed [cau_pkg::SUM_W-1:0]   sum_im;

  // Stage 3: sign and magnitude
  logic                               s3_valid;
  logic [1:0]                         s3_neg;
  logic [1:0][cau_pkg::MAG_W-1:0]     s3_mag;
  logic [cau_pkg::MAG_W-1:0]          s3_d;
  logic                               s3_dz;
  logic                               s3_is_div;
  logic signed [cau_pkg::SUM_W-1:0]   abs_re;
  logic signed [cau_pkg::SUM_W-1:0]   abs_im;
  logic [cau_pkg::MAG_W-1:0]          mag_re;
  logic [cau_pkg::MAG_W-1:0]          mag_im;

  cau_pkg::clip_t                     c3_re;
  cau_pkg::clip_t                     c3_im;
  cau_pkg::side_t                     s3_side;

  // Divider outputs
  logic                               dv_valid;
  cau_pkg::side_t                     dv_side;
  logic [1:0]                         dv_neg;
  logic [1:0]                         dv_ovf;
  logic [1:0][cau_pkg::DATA_W-1:0]    dv_q;
  cau_pkg::clip_t                     cd_re;
  cau_pkg::clip_t                     cd_im;
  cau_pkg::data_t                     fin_re;
  cau_pkg::data_t                     fin_im;
  cau_pkg::flag_t                     fin_flags;

  // Polar outputs and output buffer
  logic                               pol_valid;
  cau_pkg::result_t                   pol_res;
  cau_pkg::result_t                   obuf [0:1];
  logic                               wr_ptr;
  logic                               rd_ptr;
  logic [1:0]                         cnt;

  // Global advance: hold only when the last stage cannot drain
  assign adv      = !pol_valid || (cnt != 2'd2) || out_ready;
  assign in_ready = adv;

  // Stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op   <= op;
      s1_ar   <= a_re;
      s1_ai   <= a_im;
      s1_br   <= b_re;
      s1_bi   <= b_im;
      s1_p_rr <= a_re * b_re;
      s1_p_ii <= a_im * b_im;
      s1_p_ri <= a_re * b_im;
      s1_p_ir <= a_im * b_re;
      s1_sq_r <= b_re * b_re;
      s1_sq_i <= b_im * b_im;
    end
  end

  // Stage 2: pick the exact real and imaginary sums for the op
  always_comb begin
    unique case (s1_op)
      cau_pkg::OP_ADD: begin
        sum_re = sx_d(s1_ar) + sx_d(s1_br);
        sum_im = sx_d(s1_ai) + sx_d(s1_bi);
      end
      cau_pkg::OP_SUB: begin
        sum_re = sx_d(s1_ar) - sx_d(s1_br);
        sum_im = sx_d(s1_ai) - sx_d(s1_bi);
      end
      cau_pkg::OP_MUL: begin
        sum_re = sx_p(s1_p_rr) - sx_p(s1_p_ii);
        sum_im = sx_p(s1_p_ri) + sx_p(s1_p_ir);
      end
      cau_pkg::OP_DIV: begin
        sum_re = sx_p(s1_p_rr) + sx_p(s1_p_ii);
        sum_im = sx_p(s1_p_ir) - sx_p(s1_p_ri);
      end
      cau_pkg::OP_NEG: begin
        sum_re = -sx_d(s1_ar);
        sum_im = -sx_d(s1_ai);
      end
      cau_pkg::OP_CONJ: begin
        sum_re = sx_d(s1_ar);
        sum_im = -sx_d(s1_ai);
      end
      default: begin
        sum_re = sx_d(s1_ar);
        sum_im = sx_d(s1_ai);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sum_re <= sum_re;
      s2_sum_im <= sum_im;
      s2_d      <= $unsigned(s1_sq_r) + $unsigned(s1_sq_i);
      s2_dz     <= (s1_op == cau_pkg::OP_DIV) && (s1_br == '0) && (s1_bi == '0);
      s2_is_div <= (s1_op == cau_pkg::OP_DIV);
      s2_is_mul <= (s1_op == cau_pkg::OP_MUL);
    end
  end

  // Stage 3: magnitudes; multiply sums drop their fraction toward zero
  always_comb begin
    abs_re = s2_sum_re[cau_pkg::SUM_W-1] ? -s2_sum_re : s2_sum_re;
    abs_im = s2_sum_im[cau_pkg::SUM_W-1] ? -s2_sum_im : s2_sum_im;
    mag_re = abs_re[cau_pkg::MAG_W-1:0];
    mag_im = abs_im[cau_pkg::MAG_W-1:0];
    if (s2_is_mul) begin
      mag_re = mag_re >> cau_pkg::FRAC_W;
      mag_im = mag_im >> cau_pkg::FRAC_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_neg    <= {s2_sum_im[cau_pkg::SUM_W-1], s2_sum_re[cau_pkg::SUM_W-1]};
      s3_mag[0] <= mag_re;
      s3_mag[1] <= mag_im;
      s3_d      <= s2_d;
      s3_dz     <= s2_dz;
      s3_is_div <= s2_is_div;
    end
  end

  // Clipped result for every op but divide rides beside the divider
  always_comb begin
    c3_re          = cau_pkg::clip_sm(s3_neg[0], s3_mag[0]);
    c3_im          = cau_pkg::clip_sm(s3_neg[1], s3_mag[1]);
    s3_side.is_div = s3_is_div;
    s3_side.dz     = s3_dz;
    s3_side.sat    = c3_re.sat | c3_im.sat;
    s3_side.re     = c3_re.val;
    s3_side.im     = c3_im.val;
  end

  cau_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s3_valid),
    .in_side   (s3_side),
    .in_neg    (s3_neg),
    .in_mag    (s3_mag),
    .in_d      (s3_d),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_neg   (dv_neg),
    .out_ovf   (dv_ovf),
    .out_q     (dv_q)
  );

  // Final rectangular result
  always_comb begin
    cd_re = cau_pkg::clip_sm(dv_neg[0], dv_ovf[0] ? {cau_pkg::MAG_W{1'b1}}
                                                  : cau_pkg::MAG_W'(dv_q[0]));
    cd_im = cau_pkg::clip_sm(dv_neg[1], dv_ovf[1] ? {cau_pkg::MAG_W{1'b1}}
                                                  : cau_pkg::MAG_W'(dv_q[1]));
    fin_flags.dz = dv_side.dz;
    if (dv_side.dz) begin
      fin_re        = '0;
      fin_im        = '0;
      fin_flags.sat = 1'b0;
    end else if (dv_side.is_div) begin
      fin_re        = cd_re.val;
      fin_im        = cd_im.val;
      fin_flags.sat = cd_re.sat | cd_im.sat;
    end else begin
      fin_re        = dv_side.re;
      fin_im        = dv_side.im;
      fin_flags.sat = dv_side.sat;
    end
  end

  cau_polar u_polar (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (dv_valid),
    .in_re     (fin_re),
    .in_im     (fin_im),
    .in_flags  (fin_flags),
    .out_valid (pol_valid),
    .out_res   (pol_res)
  );

  // Two-entry output buffer
  assign push = pol_valid && adv;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= pol_res;
    end
  end

  assign out_valid      = (cnt != 2'd0);
  assign res_re         = obuf[rd_ptr].re;
  assign res_im         = obuf[rd_ptr].im;
  assign magnitude      = obuf[rd_ptr].mag;
  assign angle_deg      = obuf[rd_ptr].ang;
  assign divide_by_zero = obuf[rd_ptr].dz;
  assign saturated      = obuf[rd_ptr].sat;

  // Checks
  `CAU_ASSERT_IMP(a_dz_zero, out_valid && divide_by_zero, res_re == '0 && res_im == '0 && magnitude == '0 && !saturated)
  `CAU_ASSERT_IMP(a_hold_full, !in_ready, pol_valid && cnt == 2'd2 && !out_ready)
  `CAU_ASSERT_IMP(a_ang_range, out_valid, angle_deg >= cau_pkg::ANG_M90 && angle_deg <= cau_pkg::ANG_270)
  `CAU_ASSERT_NXT(a_drain, cnt == 2'd1 && pop && !push, !out_valid)

endmodule

`default_nettype wire

// ===== tb/complex_arith_checker.sv =====
// Result checker for the complex arithmetic unit: predicts each result and compares it.
module complex_arith_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [cau_pkg::OP_W-1:0]          op,
  input  logic signed [cau_pkg::DATA_W-1:0] a_re,
  input  logic signed [cau_pkg::DATA_W-1:0] a_im,
  input  logic signed [cau_pkg::DATA_W-1:0] b_re,
  input  logic signed [cau_pkg::DATA_W-1:0] b_im,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [cau_pkg::DATA_W-1:0] res_re,
  input  logic signed [cau_pkg::DATA_W-1:0] res_im,
  input  logic [cau_pkg::ROOT_W-1:0]        magnitude,
  input  logic signed [cau_pkg::ANG_W-1:0]  angle_deg,
  input  logic                              divide_by_zero,
  input  logic                              saturated,
  output int                                fail_count,
  output int                                pending
);
  import cau_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    data_t                   re;
    data_t                   im;
    logic [ROOT_W-1:0]       mag;
    logic signed [ANG_W-1:0] ang;
    logic                    dz;
    logic                    sat;
  } polar_result_t;

  localparam longint ATAN_DEG [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  polar_result_t expected_q[$];
  int            result_idx;

  initial fail_count = 0;
  assign pending = expected_q.size();

  // saturate a wide signed value to DATA_W
  function automatic data_t saturate(input wide_t v, inout logic sat);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (DATA_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (DATA_W - 1));
    if (v > hi) begin
      sat = 1'b1;
      return data_t'(hi);
    end
    if (v < lo) begin
      sat = 1'b1;
      return data_t'(lo);
    end
    return data_t'(v);
  endfunction

  function automatic wide_t trunc_frac(input wide_t v);
    if (v < 0) return -((-v) >>> FRAC_W);
    return v >>> FRAC_W;
  endfunction

  function automatic logic [ROOT_W-1:0] int_sqrt(input logic [127:0] n);
    logic [127:0] root, bitv;
    root = 0;
    bitv = 128'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[ROOT_W-1:0];
  endfunction

  // vectoring CORDIC, x > 0, degrees in Q.16, clipped to +-90
  function automatic longint atan_deg(input longint x0, input longint y0);
    longint x, y, z, xs, ys, lim;
    x   = x0 * 65536;
    y   = y0 * 65536;
    z   = 0;
    lim = longint'(90) <<< ANG_FRAC;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_DEG[k];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_DEG[k];
      end
    end
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    return z;
  endfunction

  function automatic polar_result_t compute_polar(input logic [OP_W-1:0] code,
      input data_t ar, input data_t ai, input data_t br, input data_t bi);
    polar_result_t r;
    wide_t         war, wai, wbr, wbi, den;
    longint        ang;
    logic          sat;
    war = ar; wai = ai; wbr = br; wbi = bi;
    sat = 1'b0;
    r.dz = 1'b0;
    r.re = '0;
    r.im = '0;
    case (code)
      OP_ADD: begin
        r.re = saturate(war + wbr, sat);
        r.im = saturate(wai + wbi, sat);
      end
      OP_SUB: begin
        r.re = saturate(war - wbr, sat);
        r.im = saturate(wai - wbi, sat);
      end
      OP_MUL: begin
        r.re = saturate(trunc_frac(war * wbr - wai * wbi), sat);
        r.im = saturate(trunc_frac(war * wbi + wai * wbr), sat);
      end
      OP_DIV: begin
        den = wbr * wbr + wbi * wbi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          // signed division truncates toward zero
          r.re = saturate(((war * wbr + wai * wbi) <<< FRAC_W) / den, sat);
          r.im = saturate(((wai * wbr - war * wbi) <<< FRAC_W) / den, sat);
        end
      end
      OP_NEG: begin
        r.re = saturate(-war, sat);
        r.im = saturate(-wai, sat);
      end
      OP_CONJ: begin
        r.re = ar;
        r.im = saturate(-wai, sat);
      end
      default: begin
        r.re = ar;
        r.im = ai;
      end
    endcase
    r.sat = sat;
    r.mag = int_sqrt(128'(wide_t'(r.re) * wide_t'(r.re) + wide_t'(r.im) * wide_t'(r.im)));
    if (r.re > 0)
      ang = atan_deg(longint'(r.re), longint'(r.im));
    else if (r.re < 0)
      ang = atan_deg(-longint'(r.re), -longint'(r.im)) + (longint'(180) <<< ANG_FRAC);
    else if (r.im > 0)
      ang = longint'(ANG_90);
    else if (r.im < 0)
      ang = longint'(ANG_270);
    else
      ang = 0;
    r.ang = ang[ANG_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] result %0d: %s got %0h expected %0h", $realtime, result_idx, what,
             got, want);
    fail_count++;
  endtask

  // capture accepted operands, check accepted results
  always @(posedge clk) begin
    polar_result_t e;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_q.push_back(compute_polar(op, a_re, a_im, b_re, b_im));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("[%0t] result %0d arrived with nothing expected", $realtime, result_idx);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (res_re !== e.re) report_mismatch("res_re", res_re, e.re);
          if (res_im !== e.im) report_mismatch("res_im", res_im, e.im);
          if (magnitude !== e.mag) report_mismatch("magnitude", magnitude, e.mag);
          if (angle_deg !== e.ang) report_mismatch("angle_deg", angle_deg, e.ang);
          if (divide_by_zero !== e.dz) report_mismatch("divide_by_zero", divide_by_zero, e.dz);
          if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
        end
        result_idx++;
      end
    end
  end

  initial result_idx = 0;
endmodule

// ===== tb/tb.sv =====
// Top-level testbench of the complex arithmetic unit: stimulus, flow control and verdict.
module tb;
  import cau_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
  localparam int N_RANDOM   = 1300;
  localparam int STALL_LIMIT = 20000;
  localparam int IDLE_PCT_ONE  = 87;
  localparam int IDLE_PCT_BOTH = 31;
  localparam data_t D_MAX = 32'sh7FFFFFFF;
  localparam data_t D_MIN = 32'sh80000000;
  localparam data_t ONE   = 32'sh00010000;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op = '0;
  data_t             a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  data_t             res_re, res_im;
  logic [ROOT_W-1:0] magnitude;
  logic signed [ANG_W-1:0] angle_deg;
  logic              divide_by_zero, saturated;
  int                fail_count, pending;
  idle_mode_t        idle_mode = IDLE_NONE;
  logic              hold_off = 1'b0;
  int                quiet_cycles = 0;

  complex_arith_unit DUT (.*);

  complex_arith_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_off)
      out_ready <= 1'b0;
    else if (idle_mode == IDLE_RECV)
      out_ready <= ($urandom_range(99) >= IDLE_PCT_ONE);
    else if (idle_mode == IDLE_BOTH)
      out_ready <= ($urandom_range(99) >= IDLE_PCT_BOTH);
    else
      out_ready <= 1'b1;
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic data_t rand_operand();
    case ($urandom_range(9))
      0: return D_MAX;
      1: return D_MIN;
      2: return '0;
      3: return data_t'($signed($urandom_range(8)) - 4);
      4, 5: return data_t'($signed($urandom_range(32'h000FFFFF)) - 32'sh00080000);
      6: return data_t'($urandom) >>> $urandom_range(31);
      default: return data_t'($urandom);
    endcase
  endfunction

  // offer one transfer, holding it until accepted
  task automatic send(input logic [OP_W-1:0] code, input data_t ar, input data_t ai,
                      input data_t br, input data_t bi);
    int pct;
    pct = (idle_mode == IDLE_BOTH) ? IDLE_PCT_BOTH : IDLE_PCT_ONE;
    if ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) && $urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
    in_valid <= 1'b1;
    op <= code;
    a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [OP_W-1:0] code;
    data_t br, bi;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send(OP_ADD, D_MAX, D_MIN, D_MAX, D_MIN);
    send(OP_ADD, D_MIN, D_MAX, D_MIN, 1);
    send(OP_SUB, D_MIN, D_MAX, 1, -1);
    send(OP_SUB, ONE, ONE, ONE, ONE);
    send(OP_MUL, D_MAX, D_MIN, D_MAX, D_MIN);
    send(OP_MUL, D_MIN, D_MIN, D_MIN, D_MAX);
    send(OP_MUL, -3 * ONE, ONE / 2, ONE, -ONE);
    send(OP_DIV, ONE, ONE, '0, '0);
    send(OP_DIV, D_MAX, D_MIN, 1, 0);
    send(OP_DIV, 3 * ONE, -ONE, ONE, 2 * ONE);
    send(OP_DIV, D_MIN, D_MAX, D_MIN, D_MIN);
    send(OP_NEG, D_MIN, D_MIN, '0, '0);
    send(OP_NEG, D_MAX, -ONE, '0, '0);
    send(OP_CONJ, D_MIN, D_MIN, '0, '0);
    send(OP_CONJ, -ONE, ONE, '0, '0);
    send(OP_PASS, '0, '0, D_MAX, D_MAX);
    send(OP_PASS, '0, ONE, '0, '0);
    send(OP_PASS, '0, -ONE, '0, '0);
    send(OP_PASS, -ONE, '0, '0, '0);
    send(OP_PASS, -ONE, -1, '0, '0);
    send(OP_PASS, ONE, -ONE, '0, '0);
    send(OP_SPARE, D_MIN, D_MAX, -1, -1);

    // random phases that cycle through the flow-control patterns
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 260 == 0) idle_mode = idle_mode_t'((n / 260) % 4);
      if (n == 600) begin
        // fill the pipeline: receiver held off while items keep coming
        fork
          begin
            idle_mode = IDLE_NONE;
            hold_off <= 1'b1;
            repeat (400) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      code = OP_W'($urandom_range(7));
      br = rand_operand();
      bi = rand_operand();
      if (code == OP_DIV && $urandom_range(15) == 0) begin
        br = '0;
        bi = '0;
      end
      send(code, rand_operand(), rand_operand(), br, bi);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/cau_divider.sv
rtl/core/cau_polar.sv
rtl/core/complex_arith_unit.sv
tb/complex_arith_checker.sv
tb/tb.sv
